[rtl/core/ooke_pkg.sv]
// ooke_pkg: shared types and constants for the remote-switch frame encoder
// no dependencies; used by every other file of the block

package ooke_pkg;

   // fixed field widths
   localparam int CTRL_ID_W = 26;
   localparam int ID_EXT_W  = 32;
   localparam int DEV_W     = 4;
   localparam int DIM_W     = 4;
   localparam int REP_W     = 8;
   localparam int TIMER_W   = 16;
   localparam int CSR_IDX_W = 2;

   // item codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PULSE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_LOW    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP         = 2'd3;

   // register reset values
   localparam logic [TIMER_W-1:0] SHORT_PULSE_RST = 16'd275;
   localparam logic [TIMER_W-1:0] LONG_LOW_RST    = 16'd1225;
   localparam logic [TIMER_W-1:0] SYNC_LOW_RST    = 16'd2675;
   localparam logic [TIMER_W-1:0] GAP_RST         = 16'd10000;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SYNC = 2'd1,
      PH_DATA = 2'd2,
      PH_GAP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic                 op;
      logic [CTRL_ID_W-1:0] controller_id;
      logic [DEV_W-1:0]     device_code;
      logic                 group_flag;
      logic                 on_state;
      logic [DIM_W-1:0]     dim_level;
      logic [REP_W-1:0]     repeat_count;
   } req_payload_type;

   typedef struct packed {
      logic tx_level;
      logic busy_res;
      logic start_rejected;
   } rsp_payload_type;

   // segment lengths as the sequencer sees them
   typedef struct packed {
      logic [TIMER_W-1:0] short_len;
      logic [TIMER_W-1:0] long_len;
      logic [TIMER_W-1:0] sync_len;
      logic [TIMER_W-1:0] gap_len;
   } timing_cfg_type;

endpackage

[rtl/core/ooke_if.sv]
// ooke_if: valid/ready channel interfaces for command items and line-level items
// depends on ooke_pkg for the payload types

interface ooke_req_if;
   logic                     valid;
   logic                     ready;
   ooke_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ooke_rsp_if;
   logic                     valid;
   logic                     ready;
   ooke_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ooke_csr.sv]
// ooke_csr: timing registers with write port, zero pulse and low lengths forced to one tick
// depends on ooke_pkg

module ooke_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [ooke_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ooke_pkg::TIMER_W-1:0]        csr_wdata,
   output ooke_pkg::timing_cfg_type            timing
);
   import ooke_pkg::*;

   logic [TIMER_W-1:0] short_ff, long_ff, sync_ff, gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= SHORT_PULSE_RST;
         long_ff  <= LONG_LOW_RST;
         sync_ff  <= SYNC_LOW_RST;
         gap_ff   <= GAP_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SHORT_PULSE: short_ff <= csr_wdata;
            CSR_LONG_LOW:    long_ff  <= csr_wdata;
            CSR_SYNC_LOW:    sync_ff  <= csr_wdata;
            CSR_GAP:         gap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a zero gap skips the gap, other zero lengths last one tick
   assign timing.short_len = (short_ff == '0) ? TIMER_W'(1) : short_ff;
   assign timing.long_len  = (long_ff  == '0) ? TIMER_W'(1) : long_ff;
   assign timing.sync_len  = (sync_ff  == '0) ? TIMER_W'(1) : sync_ff;
   assign timing.gap_len   = gap_ff;

endmodule

[rtl/core/ooke_seq.sv]
// ooke_seq: frame state, segment timer and waveform sequencer, one item per step
// depends on ooke_pkg

module ooke_seq #(
   parameter int ADDRESS_BITS = 26
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  ooke_pkg::req_payload_type  item,
   input  ooke_pkg::timing_cfg_type   timing,
   output ooke_pkg::rsp_payload_type  result
);
   import ooke_pkg::*;

   localparam int NUM_SYMBOLS = ADDRESS_BITS + 10;
   localparam int FRAME_W     = NUM_SYMBOLS;
   localparam int SYM_W       = $clog2(NUM_SYMBOLS);

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               dim_mode_ff, dim_mode_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [1:0]         seg_ff, seg_in;
   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [REP_W-1:0]   rep_ff, rep_in;

   // start item decode
   logic [ID_EXT_W-1:0]     id_ext;
   logic [ADDRESS_BITS-1:0] addr;
   logic                    dim_nz;
   assign id_ext = {{(ID_EXT_W-CTRL_ID_W){1'b0}}, item.controller_id};
   assign addr   = id_ext[ADDRESS_BITS-1:0];
   assign dim_nz = (item.dim_level != '0);

   // current symbol bit and segment length
   logic [SYM_W-1:0]   pos;
   logic               cur_bit, marker;
   logic [TIMER_W-1:0] seg_len;
   logic [TIMER_W-1:0] timer_inc;
   logic               seg_done;
   logic [REP_W-1:0]   rep_dec;

   assign pos       = SYM_W'(NUM_SYMBOLS - 1) - sym_ff;
   assign cur_bit   = frame_ff[pos];
   assign marker    = dim_mode_ff && (sym_ff == SYM_W'(ADDRESS_BITS + 1));
   assign timer_inc = timer_ff + TIMER_W'(1);
   assign seg_done  = (timer_inc >= seg_len) || (timer_inc == '0);
   assign rep_dec   = rep_ff - REP_W'(1);

   always_comb begin
      seg_len = '0;
      unique case (phase_ff)
         PH_SYNC: seg_len = (seg_ff == 2'd0) ? timing.short_len : timing.sync_len;
         PH_GAP:  seg_len = timing.gap_len;
         PH_DATA: begin
            if (marker)
               seg_len = timing.short_len;
            else if (seg_ff == 2'd1)
               seg_len = cur_bit ? timing.long_len : timing.short_len;
            else if (seg_ff == 2'd3)
               seg_len = cur_bit ? timing.short_len : timing.long_len;
            else
               seg_len = timing.short_len;
         end
         default: seg_len = '0;
      endcase
   end

   // next state
   always_comb begin
      frame_in    = frame_ff;
      dim_mode_in = dim_mode_ff;
      sym_in      = sym_ff;
      seg_in      = seg_ff;
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      rep_in      = rep_ff;
      if (item.op == OP_START) begin
         if (phase_ff == PH_IDLE) begin
            dim_mode_in = dim_nz;
            frame_in    = {addr, item.group_flag, item.on_state & ~dim_nz,
                           item.device_code, item.dim_level};
            sym_in      = '0;
            seg_in      = '0;
            timer_in    = '0;
            rep_in      = item.repeat_count;
            phase_in    = (item.repeat_count != '0) ? PH_SYNC : PH_IDLE;
         end
      end else if (phase_ff != PH_IDLE) begin
         timer_in = timer_inc;
         if (seg_done) begin
            timer_in = '0;
            unique case (phase_ff)
               PH_SYNC: begin
                  if (seg_ff == 2'd0) begin
                     seg_in = 2'd1;
                  end else begin
                     phase_in = PH_DATA;
                     sym_in   = '0;
                     seg_in   = '0;
                  end
               end
               PH_DATA: begin
                  if (seg_ff != 2'd3) begin
                     seg_in = seg_ff + 2'd1;
                  end else if (sym_ff != SYM_W'(NUM_SYMBOLS - 1)) begin
                     sym_in = sym_ff + SYM_W'(1);
                     seg_in = '0;
                  end else if (timing.gap_len != '0) begin
                     phase_in = PH_GAP;
                     seg_in   = '0;
                  end else begin
                     rep_in   = rep_dec;
                     sym_in   = '0;
                     seg_in   = '0;
                     phase_in = (rep_dec != '0) ? PH_SYNC : PH_IDLE;
                  end
               end
               PH_GAP: begin
                  rep_in   = rep_dec;
                  sym_in   = '0;
                  seg_in   = '0;
                  phase_in = (rep_dec != '0) ? PH_SYNC : PH_IDLE;
               end
               default: ;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      result = '0;
      if (item.op == OP_START) begin
         if (phase_ff != PH_IDLE) begin
            result.start_rejected = 1'b1;
            result.busy_res       = 1'b1;
         end else begin
            result.busy_res = (item.repeat_count != '0);
         end
      end else if (phase_ff != PH_IDLE) begin
         result.busy_res = 1'b1;
         result.tx_level = (phase_ff != PH_GAP) && !seg_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff    <= '0;
         dim_mode_ff <= 1'b0;
         sym_ff      <= '0;
         seg_ff      <= '0;
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         rep_ff      <= '0;
      end else if (step) begin
         frame_ff    <= frame_in;
         dim_mode_ff <= dim_mode_in;
         sym_ff      <= sym_in;
         seg_ff      <= seg_in;
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         rep_ff      <= rep_in;
      end
   end

   a_active_has_repeats: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (rep_ff != '0))
      else $error("sequencer active with no repeats left");

   a_sync_two_segments: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SYNC) |-> !seg_ff[1])
      else $error("sync phase past its low segment");

   a_idle_tick_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (step && item.op == OP_TICK && phase_ff == PH_IDLE) |=> (phase_ff == PH_IDLE))
      else $error("tick item left idle");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(phase_ff) && $stable(timer_ff) && $stable(rep_ff)))
      else $error("sequencer state moved without an item");

endmodule

[rtl/core/ook_remote_frame_encoder.sv]
// ook_remote_frame_encoder: top level of the on/off-keyed remote-switch frame encoder
// depends on ooke_pkg, ooke_if, ooke_csr and ooke_seq
//
//   channel  dir  handshake            payload
//   req_if   in   valid/ready          op, controller_id, device_code, group_flag,
//                                      on_state, dim_level, repeat_count
//   rsp_if   out  valid/ready          tx_level, busy_res, start_rejected
//   csr_*    in   write enable only    index 0..3, 16-bit data
//
// one item per clock sustained unless rsp_if stalls; each item gives one registered result
// the rate is set by the sequencer's single timer increment and segment-length compare
// reset is synchronous and active high; it restores the register defaults and idles
// a stalled result holds in the output register while the input register takes one
// more item; back-pressure then reaches req_if.ready

module ook_remote_frame_encoder #(
   parameter int ADDRESS_BITS = 26
) (
   input  logic                             clock,
   input  logic                             reset,
   ooke_req_if.sink                         req_if,
   ooke_rsp_if.source                       rsp_if,
   input  logic                             csr_write,
   input  logic [ooke_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ooke_pkg::TIMER_W-1:0]     csr_wdata
);
   import ooke_pkg::*;

   // input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   // result register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff;

   timing_cfg_type  timing;
   rsp_payload_type step_result;
   logic            advance;
   logic            step;

   // result stage free, or emptied this cycle
   assign advance      = !out_valid_ff || rsp_if.ready;
   // the held item is worked on as it moves into the result register
   assign step         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_if.ready ? req_if.valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_if.ready)
         in_data_ff <= req_if.data;
      if (step)
         out_data_ff <= step_result;
   end

   ooke_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   ooke_seq #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .timing (timing),
      .result (step_result)
   );

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

endmodule

[test/tb_ook_remote_frame_encoder.sv]
// tb_ook_remote_frame_encoder: self-checking bench for the remote-switch frame encoder
// drives command and tick items, predicts each line-level item, checks field by field
// depends on ooke_pkg, ooke_if and the encoder top level

module tb_ook_remote_frame_encoder;
   import ooke_pkg::*;

   // frame layout: address, group, state or dim marker, device, dim
   localparam int FRAME_SYMBOLS     = CTRL_ID_W + 10;
   localparam int DIM_MARKER_SYMBOL = CTRL_ID_W + 1;
   localparam int REPORT_LIMIT      = 10;
   localparam int STALL_PERCENT     = 28;

   // predicts the line level of every tick and checks what comes back
   class frame_scoreboard;
      logic [TIMER_W-1:0]       short_len, long_len, sync_len, gap_len;
      logic [FRAME_SYMBOLS-1:0] frame_bits;
      logic                     dim_mode;
      int unsigned              sym, seg;
      phase_type                phase;
      logic [TIMER_W-1:0]       timer;
      logic [REP_W-1:0]         repeats_left;
      rsp_payload_type          expected_levels[$];
      int unsigned              failures;

      function new();
         short_len    = SHORT_PULSE_RST;
         long_len     = LONG_LOW_RST;
         sync_len     = SYNC_LOW_RST;
         gap_len      = GAP_RST;
         frame_bits   = '0;
         dim_mode     = 1'b0;
         sym          = 0;
         seg          = 0;
         phase        = PH_IDLE;
         timer        = '0;
         repeats_left = '0;
         failures     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [TIMER_W-1:0] value);
         case (idx)
            CSR_SHORT_PULSE: short_len = value;
            CSR_LONG_LOW:    long_len  = value;
            CSR_SYNC_LOW:    sync_len  = value;
            default:         gap_len   = value;
         endcase
      endfunction

      function bit busy();
         return phase != PH_IDLE;
      endfunction

      function int unsigned pending();
         return expected_levels.size();
      endfunction

      // length of the segment now on the line; zero pulse and low lengths count as one tick
      function int unsigned segment_len();
         int unsigned s, l;
         logic        one_bit;
         s = (short_len == 0) ? 1 : short_len;
         l = (long_len == 0) ? 1 : long_len;
         case (phase)
            PH_SYNC: return (seg == 0) ? s : ((sync_len == 0) ? 1 : sync_len);
            PH_GAP:  return gap_len;
            PH_DATA: begin
               one_bit = frame_bits[FRAME_SYMBOLS - 1 - sym];
               if (dim_mode && sym == DIM_MARKER_SYMBOL) return s;
               if (seg == 1) return one_bit ? l : s;
               if (seg == 3) return one_bit ? s : l;
               return s;
            end
            default: return 0;
         endcase
      endfunction

      function void close_repeat();
         repeats_left = repeats_left - 1'b1;
         sym   = 0;
         seg   = 0;
         phase = (repeats_left != 0) ? PH_SYNC : PH_IDLE;
      endfunction

      function void advance_segment();
         timer = '0;
         case (phase)
            PH_SYNC: begin
               if (seg == 0) begin
                  seg = 1;
               end else begin
                  phase = PH_DATA;
                  sym   = 0;
                  seg   = 0;
               end
            end
            PH_DATA: begin
               if (seg < 3) begin
                  seg++;
               end else if (sym + 1 < FRAME_SYMBOLS) begin
                  sym++;
                  seg = 0;
               end else begin
                  phase = PH_GAP;
                  seg   = 0;
                  if (gap_len == 0) close_repeat();
               end
            end
            PH_GAP:  close_repeat();
            default: ;
         endcase
      endfunction

      function void note_item(req_payload_type item);
         rsp_payload_type want;
         want = '0;
         if (item.op == OP_START) begin
            if (phase != PH_IDLE) begin
               want.start_rejected = 1'b1;
               want.busy_res       = 1'b1;
            end else begin
               dim_mode   = (item.dim_level != 0);
               frame_bits = {item.controller_id, item.group_flag, item.on_state & ~dim_mode,
                             item.device_code, item.dim_level};
               sym          = 0;
               seg          = 0;
               timer        = '0;
               repeats_left = item.repeat_count;
               phase        = (item.repeat_count != 0) ? PH_SYNC : PH_IDLE;
               want.busy_res = (item.repeat_count != 0);
            end
         end else if (phase != PH_IDLE) begin
            want.busy_res = 1'b1;
            want.tx_level = (phase != PH_GAP) && (seg[0] == 1'b0);
            timer = timer + 1'b1;
            if (timer >= segment_len() || timer == 0) advance_segment();
         end
         expected_levels.push_back(want);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_levels.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected item: tx_level %0b busy %0b rejected %0b",
                        got.tx_level, got.busy_res, got.start_rejected);
            return;
         end
         want = expected_levels.pop_front();
         if (got.tx_level !== want.tx_level || got.busy_res !== want.busy_res ||
             got.start_rejected !== want.start_rejected) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("mismatch: tx_level exp %0b got %0b, busy exp %0b got %0b, %s %0b got %0b",
                        want.tx_level, got.tx_level, want.busy_res, got.busy_res,
                        "rejected exp", want.start_rejected, got.start_rejected);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIMER_W-1:0]   csr_wdata;
   bit   steady;   // no idling on either side while set
   int unsigned sent_items;

   ooke_req_if req_ch ();
   ooke_rsp_if rsp_ch ();

   frame_scoreboard sb = new();

   ook_remote_frame_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // generous ceiling well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // result side stalls at random, except during the steady stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= steady || ($urandom_range(99) >= STALL_PERCENT);
      end
   end

   // sampled mid-cycle where everything is settled; accepted at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
   end

   // every field random, op set to tick
   function automatic req_payload_type tick_item();
      logic [63:0]     bits;
      req_payload_type item;
      bits = {$urandom, $urandom};
      item = bits[$bits(req_payload_type)-1:0];
      item.op = OP_TICK;
      return item;
   endfunction

   function automatic req_payload_type start_item(logic [CTRL_ID_W-1:0] id,
                                                  logic [DEV_W-1:0] dev, logic grp,
                                                  logic on, logic [DIM_W-1:0] dim,
                                                  logic [REP_W-1:0] reps);
      req_payload_type item;
      item.op            = OP_START;
      item.controller_id = id;
      item.device_code   = dev;
      item.group_flag    = grp;
      item.on_state      = on;
      item.dim_level     = dim;
      item.repeat_count  = reps;
      return item;
   endfunction

   // a random command with a short repeat count, for use while idle
   function automatic req_payload_type random_command();
      req_payload_type item;
      item = tick_item();
      item.op = OP_START;
      item.repeat_count = ($urandom_range(9) == 0) ? 8'd0 : REP_W'($urandom_range(1, 3));
      if ($urandom_range(1) == 0) item.dim_level = '0;
      return item;
   endfunction

   // holds valid until the item is taken; valid stays high for a following item
   task automatic send_item(input req_payload_type item);
      while (!steady && $urandom_range(99) < STALL_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      sb.note_item(item);
      sent_items++;
   endtask

   // sender holds off until every expected item has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // ticks until the last repeat has gone out, then drain
   task automatic finish_frames();
      while (sb.busy()) send_item(tick_item());
      wait_drained();
   endtask

   // all four timing registers in back-to-back writes; block must be idle
   task automatic program_timing(input logic [TIMER_W-1:0] short_len, long_len,
                                 input logic [TIMER_W-1:0] sync_len, gap_len);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [TIMER_W-1:0]   val [4];
      idx = '{CSR_SHORT_PULSE, CSR_LONG_LOW, CSR_SYNC_LOW, CSR_GAP};
      val = '{short_len, long_len, sync_len, gap_len};
      csr_write <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.set_reg(idx[i], val[i]);
      end
      csr_write <= 1'b0;
   endtask

   // mixed traffic: commands while idle, stray commands while busy, otherwise ticks
   task automatic random_traffic(input int unsigned n_items);
      req_payload_type item;
      repeat (n_items) begin
         item = tick_item();
         if (!sb.busy()) begin
            if ($urandom_range(99) < 35) item = random_command();
         end else if ($urandom_range(99) < 3) begin
            item.op = OP_START;   // raw fields, should bounce off
         end
         send_item(item);
         if ($urandom_range(999) < 3) wait_drained();
      end
      finish_frames();
   endtask

   initial begin : stimulus
      req_payload_type item;
      int unsigned     n;

      reset        = 1'b1;
      steady       = 1'b0;
      sent_items   = 0;
      csr_write    = 1'b0;
      csr_index    = CSR_SHORT_PULSE;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset timing: idle tick and a zero-repeat command
      send_item(tick_item());
      send_item(start_item('1, 4'hf, 1'b1, 1'b1, 4'hf, 8'd0));
      wait_drained();

      // zero lengths fall back to one tick, zero gap is skipped
      program_timing(16'd0, 16'd0, 16'd0, 16'd0);
      send_item(start_item(26'h3ffffff, 4'hf, 1'b1, 1'b1, 4'h0, 8'd2));
      item = tick_item();
      item.op = OP_START;
      send_item(item);            // start while busy is bounced
      finish_frames();
      // dim mode: state bit forced low, marker symbol replaces it
      send_item(start_item(26'h0, 4'h0, 1'b0, 1'b1, 4'hf, 8'd1));
      finish_frames();
      send_item(start_item(26'h2aaaaaa, 4'h5, 1'b0, 1'b0, 4'h1, 8'd1));
      finish_frames();

      program_timing(16'd2, 16'd5, 16'd4, 16'd3);
      send_item(start_item(26'h1555555, 4'ha, 1'b1, 1'b0, 4'h0, 8'd1));
      send_item(start_item('1, 4'h3, 1'b0, 1'b1, 4'h0, 8'd0));   // bounced despite zero repeats
      finish_frames();

      // long sync low and gap, run flat out with no idling at all
      steady = 1'b1;
      program_timing(16'd1, 16'd1, 16'd40, 16'd40);
      item = random_command();
      item.repeat_count = 8'd1;
      send_item(item);
      finish_frames();
      steady = 1'b0;

      // random part: small timings so that whole frames finish often
      while (sent_items < 1500) begin
         program_timing(TIMER_W'($urandom_range(0, 2)), TIMER_W'($urandom_range(0, 4)),
                        TIMER_W'($urandom_range(0, 5)), TIMER_W'($urandom_range(0, 12)));
         n = $urandom_range(120, 250);
         random_traffic(n);
      end

      // longest short segment; stray starts bounce while the sync pulse is still high
      program_timing(16'hffff, 16'hffff, 16'd1, 16'd1);
      item = random_command();
      item.repeat_count = 8'd255;
      send_item(item);
      repeat (100) begin
         item = tick_item();
         if ($urandom_range(19) == 0) item.op = OP_START;
         send_item(item);
      end

      wait_drained();
      repeat (8) @(posedge clock);   // catch any stray late item
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
